/* hdl/blp_pkg.sv */
// Package for the bit-angle LED plane scanner: action codes, default
// geometry and the enable PWM compare function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blp_pkg;

  localparam int PLANE_BYTES_N_DEF = 32;
  localparam int PLANE_COUNT_DEF   = 8;

  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_REQ   = 3'd1;
  localparam logic [2:0] ACT_FORCE = 3'd2;
  localparam logic [2:0] ACT_CLEAR = 3'd3;
  localparam logic [2:0] ACT_SCAN  = 3'd4;

  localparam int DIM_FULL  = 256;
  localparam int DIM_ROUND = 127;
  localparam int DIM_SCALE = 255;

  // on = (256*b + 127) / 255 reduces to b + (b > 127) for 8-bit b.
  function automatic logic [7:0] dim_cmp(input logic [7:0] b);
    logic [8:0] on;
    logic [8:0] cmp;
    on = {1'b0, b} + ((b > 8'(DIM_ROUND)) ? 9'd1 : 9'd0);
    cmp = 9'(DIM_FULL) - on;
    if (b == 8'd0) begin
      cmp = 9'(DIM_SCALE);
    end
    return cmp[7:0];
  endfunction

endpackage

`default_nettype wire

/* hdl/blp_frame_store.sv */
// Double frame store: one write port, one read port, read data registered.
// Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module blp_frame_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/bit_angle_led_plane_scanner_unit.sv */
// Bit-angle LED plane scanner, top level.
// Depends on blp_pkg and blp_frame_store.
//
// Usage:
//   Commands enter on start/in_action/in_address/in_data and are taken when
//   start is high and busy is low. Write, swap request and force swap leave
//   busy low. Clear back frame holds busy while the back frame is zeroed,
//   one memory word per cycle. A scan tick holds busy while the plane is
//   read out of the frame memory, one word per cycle through its single
//   read port; results come through the registered read data and strobe,
//   one word per cycle with out_strobe high, the last word flagged by
//   out_latch. The next command may be taken in the cycle that shows the
//   last word.
//   The brightness register is written over cfg_valid/cfg_data (cfg_ready
//   is always high) and is only to be changed while no scan is in flight.
//   After reset busy stays high while both frames are cleared, one word per
//   cycle; cfg writes are taken meanwhile. Results cannot be held off: each
//   word is valid for exactly the cycle its strobe is high.
`timescale 1ns / 1ps
`default_nettype none

module bit_angle_led_plane_scanner_unit #(
  parameter int PLANE_BYTES_N = blp_pkg::PLANE_BYTES_N_DEF,
  parameter int PLANE_COUNT   = blp_pkg::PLANE_COUNT_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] in_action,
  input  wire logic [7:0] in_address,
  input  wire logic [7:0] in_data,
  output logic            out_strobe,
  output logic [7:0]      out_plane_byte,
  output logic [2:0]      out_plane_number,
  output logic            out_latch,
  output logic [7:0]      out_dim_compare,
  output logic            out_outputs_off,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data
);
  import blp_pkg::*;

  localparam int FRAME_LEN   = PLANE_BYTES_N * PLANE_COUNT;
  localparam int DEPTH       = 2 * FRAME_LEN;
  localparam int AW          = $clog2(DEPTH);
  localparam int PW          = (PLANE_COUNT > 2) ? $clog2(PLANE_COUNT) : 1;
  localparam int TW          = PLANE_COUNT;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_INIT  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;
  localparam logic [1:0] ST_SCAN  = 2'd3;

  localparam logic [AW-1:0] FRAME_OFS  = AW'(FRAME_LEN);
  localparam logic [AW-1:0] INIT_LAST  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] CLEAR_LAST = AW'(FRAME_LEN - 1);
  localparam logic [AW-1:0] SCAN_LAST  = AW'(PLANE_BYTES_N - 1);
  localparam logic [TW-1:0] TICK_LAST  = TW'((1 << PLANE_COUNT) - 2);

  logic [1:0]    state_r, state_nxt;
  logic          front_r, front_nxt;
  logic          swap_req_r, swap_req_nxt;
  logic [TW-1:0] tick_r, tick_nxt;
  logic [7:0]    bright_r, bright_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] plane_r, plane_nxt;
  logic          strobe_r, strobe_nxt;
  logic          latch_r, latch_nxt;

  logic          accept;
  logic [AW-1:0] back_base;
  logic [PW-1:0] plane_sel;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [7:0]    rd_data;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign back_base = front_r ? '0 : FRAME_OFS;

  // Plane = (PLANE_COUNT-1) minus trailing ones of the tick.
  always_comb begin
    logic done;
    done = 1'b0;
    plane_sel = PW'(PLANE_COUNT - 1);
    for (int k = 0; k < PLANE_COUNT - 1; k++) begin
      if (!done && tick_r[k]) begin
        plane_sel = plane_sel - PW'(1);
      end else begin
        done = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    swap_req_nxt = swap_req_r;
    tick_nxt     = tick_r;
    bright_nxt   = bright_r;
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    plane_nxt    = plane_r;
    strobe_nxt   = 1'b0;
    latch_nxt    = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = addr_r;
    wr_data      = 8'd0;
    rd_en        = 1'b0;

    if (cfg_valid) begin
      bright_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_WRITE: begin
              if (int'(in_address) < FRAME_LEN) begin
                wr_en   = 1'b1;
                wr_addr = back_base + AW'(in_address);
                wr_data = in_data;
              end
            end
            ACT_REQ: begin
              swap_req_nxt = 1'b1;
            end
            ACT_FORCE: begin
              if (swap_req_r) begin
                front_nxt    = !front_r;
                swap_req_nxt = 1'b0;
              end
            end
            ACT_CLEAR: begin
              state_nxt = ST_CLEAR;
              cnt_nxt   = '0;
              addr_nxt  = back_base;
            end
            ACT_SCAN: begin
              state_nxt = ST_SCAN;
              cnt_nxt   = '0;
              plane_nxt = plane_sel;
              addr_nxt  = (front_r ? FRAME_OFS : '0)
                          + AW'(int'(plane_sel) * PLANE_BYTES_N);
            end
            default: begin
            end
          endcase
        end
      end
      ST_INIT, ST_CLEAR: begin
        wr_en    = 1'b1;
        cnt_nxt  = cnt_r + AW'(1);
        addr_nxt = addr_r + AW'(1);
        if ((state_r == ST_INIT && cnt_r == INIT_LAST)
            || (state_r == ST_CLEAR && cnt_r == CLEAR_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        rd_en      = 1'b1;
        strobe_nxt = 1'b1;
        cnt_nxt    = cnt_r + AW'(1);
        addr_nxt   = addr_r + AW'(1);
        if (cnt_r == SCAN_LAST) begin
          latch_nxt = 1'b1;
          state_nxt = ST_IDLE;
          // tick wraps one short of all ones; a pending swap lands here
          if (tick_r == TICK_LAST) begin
            tick_nxt = '0;
            if (swap_req_r) begin
              front_nxt    = !front_r;
              swap_req_nxt = 1'b0;
            end
          end else begin
            tick_nxt = tick_r + TW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      front_r    <= 1'b0;
      swap_req_r <= 1'b0;
      tick_r     <= '0;
      bright_r   <= 8'(DIM_SCALE);
      cnt_r      <= '0;
      addr_r     <= '0;
      strobe_r   <= 1'b0;
      latch_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      front_r    <= front_nxt;
      swap_req_r <= swap_req_nxt;
      tick_r     <= tick_nxt;
      bright_r   <= bright_nxt;
      cnt_r      <= cnt_nxt;
      addr_r     <= addr_nxt;
      strobe_r   <= strobe_nxt;
      latch_r    <= latch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plane_r <= plane_nxt;
  end

  blp_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  assign out_strobe       = strobe_r;
  assign out_plane_byte   = rd_data;
  assign out_plane_number = 3'(plane_r);
  assign out_latch        = latch_r;
  assign out_dim_compare  = dim_cmp(bright_r);
  assign out_outputs_off  = (bright_r == 8'd0);

endmodule

`default_nettype wire

/* hdl/blp_checker.sv */
// Port-level checks for the plane scanner, bound to the top level.
// Depends on blp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module blp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [2:0] in_action,
  input wire logic       out_strobe,
  input wire logic       out_latch,
  input wire logic [7:0] out_dim_compare,
  input wire logic       out_outputs_off
);
  import blp_pkg::*;

  // a word only follows a cycle of plane readout
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without readout");

  a_latch_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_latch |-> out_strobe)
    else $error("latch outside a word");

  // plane words come back to back until the latch
  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_latch |=> out_strobe)
    else $error("gap inside a plane");

  a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_action == ACT_SCAN |=> busy)
    else $error("scan tick did not raise busy");

  a_off_compare: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_outputs_off |-> out_dim_compare == 8'(DIM_SCALE))
    else $error("outputs off with wrong compare");

endmodule

bind bit_angle_led_plane_scanner_unit blp_checker u_blp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_action       (in_action),
  .out_strobe      (out_strobe),
  .out_latch       (out_latch),
  .out_dim_compare (out_dim_compare),
  .out_outputs_off (out_outputs_off)
);

`default_nettype wire

/* tb/tb_bit_angle_led_plane_scanner_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for bit_angle_led_plane_scanner_unit: directed and random commands
// with brightness changes between phases; strobed words are checked against a local frame model.
// Depends on blp_pkg and the scanner RTL.

module tb_bit_angle_led_plane_scanner_unit;
  import blp_pkg::*;

  localparam int ROW_BYTES     = PLANE_BYTES_N_DEF;
  localparam int PLANES        = PLANE_COUNT_DEF;
  localparam int FRAME_LEN     = ROW_BYTES * PLANES;
  localparam int TICK_WRAP     = (1 << PLANES) - 1;
  localparam int SETTLE_CYCLES = FRAME_LEN + 16;  // quiet time before a brightness write
  localparam int TAIL_CYCLES   = FRAME_LEN + 40;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {STEP_CMD, STEP_BRIGHT, STEP_DRAIN, STEP_PACE} step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [2:0] action;
    logic [7:0] address;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic [7:0] pbyte;
    logic [2:0] pnum;
    logic       latch;
    logic [7:0] dimc;
    logic       off;
  } plane_word_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic [2:0] in_action = '0;
  logic [7:0] in_address = '0;
  logic [7:0] in_data = '0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_data = '0;
  logic       busy;
  logic       out_strobe;
  logic [7:0] out_plane_byte;
  logic [2:0] out_plane_number;
  logic       out_latch;
  logic [7:0] out_dim_compare;
  logic       out_outputs_off;
  logic       cfg_ready;

  // local copy of the scanner state
  logic [7:0] led_frame [2*FRAME_LEN];
  logic       front_sel;
  logic       swap_pend;
  int         scan_tick;
  logic [7:0] bright;

  step_t       cmd_backlog[$];
  plane_word_t plane_words_due[$];

  logic cmd_taken = 1'b0;
  logic bright_taken = 1'b0;
  int   idle_pct = 0;
  int   settle_cnt = 0;
  int   cycle_cnt = 0;
  int   err_cnt = 0;
  int   words_checked = 0;
  int   scans_done = 0;
  int   swaps_done = 0;
  int   wraps_seen = 0;
  int   bright_writes = 0;

  bit_angle_led_plane_scanner_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_address       (in_address),
    .in_data          (in_data),
    .out_strobe       (out_strobe),
    .out_plane_byte   (out_plane_byte),
    .out_plane_number (out_plane_number),
    .out_latch        (out_latch),
    .out_dim_compare  (out_dim_compare),
    .out_outputs_off  (out_outputs_off),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  function automatic logic [7:0] enable_compare(input logic [7:0] level);
    int on_cnt;
    if (level == 8'd0) begin
      return 8'(DIM_SCALE);
    end
    on_cnt = (DIM_FULL * int'(level) + DIM_ROUND) / DIM_SCALE;
    if (on_cnt > DIM_FULL) begin
      on_cnt = DIM_FULL;
    end
    return 8'(DIM_FULL - on_cnt);
  endfunction

  function automatic int back_base();
    return front_sel ? 0 : FRAME_LEN;
  endfunction

  task automatic take_swap();
    if (swap_pend) begin
      front_sel = ~front_sel;
      swap_pend = 1'b0;
      swaps_done++;
    end
  endtask

  task automatic reset_scanner_model();
    for (int i = 0; i < 2*FRAME_LEN; i++) begin
      led_frame[i] = 8'h00;
    end
    front_sel = 1'b0;
    swap_pend = 1'b0;
    scan_tick = 0;
    bright = 8'hFF;
  endtask

  task automatic run_scanner_cmd(input logic [2:0] act, input logic [7:0] addr,
                                 input logic [7:0] val);
    int plane;
    int t;
    int base;
    plane_word_t w;
    case (act)
      ACT_WRITE: begin
        if (int'(addr) < FRAME_LEN) begin
          led_frame[back_base() + int'(addr)] = val;
        end
      end
      ACT_REQ: begin
        swap_pend = 1'b1;
      end
      ACT_FORCE: begin
        take_swap();
      end
      ACT_CLEAR: begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          led_frame[back_base() + i] = 8'h00;
        end
      end
      ACT_SCAN: begin
        // plane = top plane minus trailing ones of the tick
        t = scan_tick;
        plane = PLANES - 1;
        while ((t & 1) != 0 && plane > 0) begin
          plane--;
          t = t >> 1;
        end
        base = (front_sel ? FRAME_LEN : 0) + plane * ROW_BYTES;
        for (int i = 0; i < ROW_BYTES; i++) begin
          w.pbyte = led_frame[base + i];
          w.pnum  = 3'(plane);
          w.latch = (i == ROW_BYTES - 1);
          w.dimc  = enable_compare(bright);
          w.off   = (bright == 8'd0);
          plane_words_due.push_back(w);
        end
        scans_done++;
        scan_tick++;
        if (scan_tick >= TICK_WRAP) begin
          scan_tick = 0;
          wraps_seen++;
          take_swap();
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_word();
    plane_word_t want;
    if (plane_words_due.size() == 0) begin
      flag_mismatch("word with none due, plane_byte", out_plane_byte, 0);
      return;
    end
    want = plane_words_due.pop_front();
    words_checked++;
    if (out_plane_byte !== want.pbyte) flag_mismatch("plane_byte", out_plane_byte, want.pbyte);
    if (out_plane_number !== want.pnum) begin
      flag_mismatch("plane_number", out_plane_number, want.pnum);
    end
    if (out_latch !== want.latch) flag_mismatch("latch", out_latch, want.latch);
    if (out_dim_compare !== want.dimc) begin
      flag_mismatch("dim_compare", out_dim_compare, want.dimc);
    end
    if (out_outputs_off !== want.off) flag_mismatch("outputs_off", out_outputs_off, want.off);
  endtask

  // sample everything at the rising edge
  always @(posedge clk) begin
    cycle_cnt++;
    cmd_taken = 1'b0;
    bright_taken = 1'b0;
    if (!rst_n) begin
      reset_scanner_model();
    end else begin
      if (out_strobe) begin
        check_word();
      end
      if (start && !busy) begin
        cmd_taken = 1'b1;
        run_scanner_cmd(in_action, in_address, in_data);
      end
      if (cfg_valid && cfg_ready) begin
        bright_taken = 1'b1;
        bright = cfg_data;
        bright_writes++;
      end
    end
  end

  // drive at the falling edge, one assignment per signal
  always @(negedge clk) begin
    step_t head;
    logic  nxt_start;
    logic  nxt_cfg;
    nxt_start = start && !cmd_taken;
    nxt_cfg = cfg_valid && !bright_taken;
    if (cmd_taken || plane_words_due.size() != 0) begin
      settle_cnt = 0;
    end
    if (rst_n && !nxt_start && !nxt_cfg && cmd_backlog.size() > 0) begin
      head = cmd_backlog[0];
      case (head.kind)
        STEP_PACE: begin
          idle_pct = int'(head.data);
          void'(cmd_backlog.pop_front());
        end
        STEP_DRAIN: begin
          if (plane_words_due.size() == 0) void'(cmd_backlog.pop_front());
        end
        STEP_BRIGHT: begin
          if (plane_words_due.size() != 0 || settle_cnt < SETTLE_CYCLES) begin
            settle_cnt++;
          end else begin
            void'(cmd_backlog.pop_front());
            cfg_data <= head.data;
            nxt_cfg = 1'b1;
            settle_cnt = 0;
          end
        end
        default: begin
          if (int'($urandom_range(99)) >= idle_pct) begin
            void'(cmd_backlog.pop_front());
            in_action <= head.action;
            in_address <= head.address;
            in_data <= head.data;
            nxt_start = 1'b1;
          end
        end
      endcase
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  function automatic void push_step(step_kind_t kind, logic [2:0] act, logic [7:0] addr,
                                    logic [7:0] val);
    step_t s;
    s.kind = kind;
    s.action = act;
    s.address = addr;
    s.data = val;
    cmd_backlog.push_back(s);
  endfunction

  function automatic void push_cmd(logic [2:0] act, logic [7:0] addr, logic [7:0] val);
    push_step(STEP_CMD, act, addr, val);
  endfunction

  function automatic void push_bright(logic [7:0] level);
    push_step(STEP_BRIGHT, ACT_WRITE, 8'h00, level);
  endfunction

  // mostly scan ticks so the tick wraps and pending swaps land there
  task automatic queue_random_cmds(input int n);
    int         pick;
    logic [7:0] lvl;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (i % 40 == 39) begin
        lvl = ($urandom_range(2) == 0) ? (($urandom_range(1) == 0) ? 8'h00 : 8'hFF)
                                       : 8'($urandom);
        push_bright(lvl);
      end
      if (i % 50 == 24) push_step(STEP_DRAIN, ACT_WRITE, 8'h00, 8'h00);
      if (pick < 84) begin
        push_cmd(ACT_SCAN, 8'($urandom), 8'($urandom));
      end else if (pick < 94) begin
        push_cmd(ACT_WRITE, 8'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        push_cmd(ACT_REQ, 8'($urandom), 8'($urandom));
      end else if (pick < 98) begin
        push_cmd(ACT_FORCE, 8'($urandom), 8'($urandom));
      end else if (pick < 99) begin
        push_cmd(ACT_CLEAR, 8'($urandom), 8'($urandom));
      end else begin
        push_cmd(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    // directed: blank frame, writes at the extremes, swap rules, spare codes, clear, brightness steps
    push_step(STEP_PACE, ACT_WRITE, 8'h00, 8'd36);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_cmd(ACT_WRITE, 8'h00, 8'hFF);
    push_cmd(ACT_WRITE, 8'hFF, 8'h80);
    push_cmd(ACT_WRITE, 8'hE0, 8'h01);
    push_cmd(ACT_WRITE, 8'hE6, 8'h7F);
    push_cmd(ACT_FORCE, 8'h00, 8'h00);   // nothing pending
    push_cmd(ACT_SCAN, 8'hFF, 8'hFF);
    push_cmd(ACT_REQ, 8'h00, 8'h00);
    push_cmd(ACT_REQ, 8'h00, 8'h00);
    push_cmd(ACT_FORCE, 8'h00, 8'h00);
    push_cmd(ACT_FORCE, 8'h00, 8'h00);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
      push_cmd(3'(a), 8'hFF, 8'hFF);
    end
    push_cmd(ACT_WRITE, 8'h1F, 8'hAA);
    push_cmd(ACT_CLEAR, 8'h00, 8'h00);
    push_step(STEP_DRAIN, ACT_WRITE, 8'h00, 8'h00);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_bright(8'd0);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_bright(8'd1);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_bright(8'd127);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_bright(8'd128);
    push_cmd(ACT_SCAN, 8'h00, 8'h00);
    push_bright(8'd255);

    queue_random_cmds(96);
    push_step(STEP_PACE, ACT_WRITE, 8'h00, 8'd61);
    push_bright(8'($urandom));
    queue_random_cmds(96);
    push_step(STEP_PACE, ACT_WRITE, 8'h00, 8'd0);
    push_bright(8'd0);
    queue_random_cmds(96);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!(cmd_backlog.size() == 0 && !start && !cfg_valid && plane_words_due.size() == 0)
           && cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    if (cycle_cnt < CYCLE_LIMIT) begin
      repeat (TAIL_CYCLES) @(posedge clk);
    end

    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("FAILURE");
    end else begin
      if (plane_words_due.size() != 0) begin
        flag_mismatch("words never seen, count", 0, plane_words_due.size());
      end
      $display("run: %0d scan ticks, %0d words checked, %0d swaps, %0d tick wraps",
               scans_done, words_checked, swaps_done, wraps_seen);
      $display("run: %0d brightness writes, %0d mismatches", bright_writes, err_cnt);
      if (err_cnt == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule

/* bit_angle_led_plane_scanner_unit.f */
hdl/blp_pkg.sv
hdl/blp_frame_store.sv
hdl/bit_angle_led_plane_scanner_unit.sv
hdl/blp_checker.sv
tb/tb_bit_angle_led_plane_scanner_unit.sv
